/* hdl/e2e_pkg.sv */
// Package: item types, opcodes, status codes and the CRC-8 byte step.
package e2e_pkg;

	// Frame modes carried by the opcode of a frame's first item
	localparam logic [1:0] OP_PROTECT = 2'd0;
	localparam logic [1:0] OP_FORWARD = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_DATA_ID   = 2'd0;
	localparam logic [1:0] REG_MAX_DELTA = 2'd1;
	localparam logic [1:0] REG_CRC_START = 2'd2;

	// CRC-8 SAE J1850 polynomial and values that do not vary
	localparam logic [7:0] CRC_POLY      = 8'h1D;
	localparam logic [7:0] CRC_START_RST = 8'hFF;
	localparam logic [3:0] COUNT_WRAP    = 4'd14;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_REPEATED  = 3'd1,
		ST_WRONG_SEQ = 3'd2,
		ST_WRONG_CRC = 3'd3,
		ST_NO_NEW    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] crc_out;
		logic [7:0] control_out;
	} out_item_t;

	// One byte through the CRC register, MSB first
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hdl/e2e_crc8_counter_protect_check.sv */
// Top level: E2E CRC-8 header protect, forward and check unit.
//
// Frames arrive one byte per item; the opcode of a frame's first item picks
// protect, forward or check, and the item with last set ends the frame and
// yields one result (status, inverted CRC-8, control byte). The block takes
// one item per cycle: the running CRC advances one byte per cycle (plus the
// control byte on a frame's first item), which is the loop that sets that
// figure. After reset and after each configuration write the data-id CRC
// prefix is recomputed, and items are stalled while that happens. Apart
// from that, a last item is stalled only while the result register is full
// and its result is stalled; other items keep flowing.
module e2e_crc8_counter_protect_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  e2e_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output e2e_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import e2e_pkg::*;

	// Configuration and derived prefix
	logic [15:0] data_id_q;
	logic [3:0]  max_delta_q;
	logic [7:0]  crc_start_q;
	logic [7:0]  prefix_q;
	logic        pend_q;

	// Frame state
	logic        active_q;
	logic [1:0]  mode_q;
	logic [1:0]  pos_q;
	logic        seen_q;
	logic [7:0]  run_q;
	logic [7:0]  rcrc_q;
	logic [7:0]  rctl_q;
	logic [3:0]  protect_q;
	logic [3:0]  check_q;

	// Result register
	out_item_t   result_q;
	logic        result_valid_q;

	logic        acc;
	logic        take;
	logic        cfg_wr;
	logic        start;
	logic [1:0]  mode;
	logic        is_check;
	logic [3:0]  next_prot;
	logic [7:0]  ctl_gen;
	logic [7:0]  crc_a;
	logic [7:0]  rctl_a;
	logic [7:0]  rcrc_a;
	logic [1:0]  pos_a;
	logic        seen_a;
	logic [7:0]  crc_b;
	logic [7:0]  rctl_b;
	logic [7:0]  rcrc_b;
	logic [1:0]  pos_b;
	logic        seen_b;
	logic [7:0]  crc_fin;
	logic [3:0]  rc;
	logic [3:0]  diff;
	out_item_t   res_d;
	logic        crc_good;

	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign take         = result_valid_q && !result_stall;
	assign item_stall   = pend_q || (result_valid_q && result_stall && item.last);
	assign acc          = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Frame start: pick mode, build control byte, seed the CRC
	always_comb begin
		start     = !active_q;
		mode      = start ? item.opcode : mode_q;
		is_check  = mode[1];
		next_prot = (protect_q < COUNT_WRAP) ? protect_q + 4'd1 : 4'd0;
		ctl_gen   = {data_id_q[15:12], (mode == OP_PROTECT) ? next_prot : check_q};
		if (start) begin
			crc_a  = is_check ? prefix_q : crc_byte(prefix_q, ctl_gen);
			rctl_a = is_check ? 8'd0 : ctl_gen;
			rcrc_a = 8'd0;
			pos_a  = 2'd0;
			seen_a = 1'b0;
		end else begin
			crc_a  = run_q;
			rctl_a = rctl_q;
			rcrc_a = rcrc_q;
			pos_a  = pos_q;
			seen_a = seen_q;
		end
	end

	// Take the item's byte: header bytes then payload on check, payload otherwise
	always_comb begin
		crc_b  = crc_a;
		rctl_b = rctl_a;
		rcrc_b = rcrc_a;
		pos_b  = pos_a;
		seen_b = seen_a;
		if (item.byte_valid) begin
			if (!is_check || pos_a == 2'd2) begin
				crc_b  = crc_byte(crc_a, item.data_byte);
				seen_b = 1'b1;
			end else if (pos_a == 2'd0) begin
				rcrc_b = item.data_byte;
				pos_b  = 2'd1;
			end else begin
				rctl_b = item.data_byte;
				crc_b  = crc_byte(crc_a, item.data_byte);
				pos_b  = 2'd2;
			end
		end
	end

	// Classify the finished frame
	always_comb begin
		crc_fin  = ~crc_b;
		rc       = rctl_b[3:0];
		diff     = rc - check_q;
		crc_good = (rcrc_b == crc_fin);
		res_d    = '{status: ST_OK, crc_out: crc_fin, control_out: rctl_b};
		if (!seen_b) begin
			res_d = '{status: is_check ? ST_NO_NEW : ST_EMPTY, crc_out: 8'd0,
				control_out: 8'd0};
		end else if (is_check) begin
			if (!crc_good) begin
				res_d.status = ST_WRONG_CRC;
			end else if (rc == check_q) begin
				res_d.status = ST_REPEATED;
			end else if (rc < check_q || diff > max_delta_q) begin
				res_d.status = ST_WRONG_SEQ;
			end else begin
				res_d.status = ST_OK;
			end
		end
	end

	// Configuration registers; recompute the data-id prefix in the cycle after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_id_q   <= 16'd0;
			max_delta_q <= 4'd0;
			crc_start_q <= CRC_START_RST;
			pend_q      <= 1'b1;
		end else begin
			pend_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_DATA_ID:   data_id_q   <= cfg_data;
					REG_MAX_DELTA: max_delta_q <= cfg_data[3:0];
					REG_CRC_START: crc_start_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			prefix_q <= crc_byte(crc_byte(crc_start_q, data_id_q[15:8]), data_id_q[7:0]);
		end
	end

	// Advance frame state on each accepted item, and the counters on the last item of a frame with payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			mode_q    <= OP_PROTECT;
			pos_q     <= 2'd0;
			seen_q    <= 1'b0;
			run_q     <= 8'd0;
			rcrc_q    <= 8'd0;
			rctl_q    <= 8'd0;
			protect_q <= 4'd0;
			check_q   <= 4'd0;
		end else if (acc) begin
			active_q <= !item.last;
			mode_q   <= mode;
			pos_q    <= pos_b;
			seen_q   <= seen_b;
			run_q    <= crc_b;
			rcrc_q   <= rcrc_b;
			rctl_q   <= rctl_b;
			if (item.last && seen_b) begin
				if (!is_check) begin
					protect_q <= (mode == OP_PROTECT) ? next_prot : check_q;
				end else if (crc_good) begin
					check_q <= rc;
				end
			end
		end
	end

	// Result register: load on a last item, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (acc && item.last) begin
			result_valid_q <= 1'b1;
		end else if (take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && item.last) begin
			result_q <= res_d;
		end
	end

	// A last item always yields a result in the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.last |=> result_valid)
		else $error("last item did not produce a result");

	// Other items never create a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !item.last && (!result_valid || !result_stall) |=> !result_valid)
		else $error("result appeared without a last item");

	// No item is taken while the prefix is being recomputed
	a_prefix_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> item_stall)
		else $error("item accepted during prefix update");

	// Frames with no payload bytes (status EMPTY or NO_NEW) carry no header bytes
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_EMPTY || result.status == ST_NO_NEW)
		|-> result.crc_out == 8'd0 && result.control_out == 8'd0)
		else $error("rejected frame carries header bytes");

endmodule
